@@ src/palette_color_matcher_assert.svh @@
// Assertion macros for the palette color matcher.
`ifndef PALETTE_COLOR_MATCHER_ASSERT_SVH
`define PALETTE_COLOR_MATCHER_ASSERT_SVH

`ifndef SYNTH
`define PCM_ASSERT_IMPL(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PCM_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PCM_ASSERT_IMPL(label, clock, resetn, ante, cons)
`define PCM_ASSERT_NEXT(label, clock, resetn, ante, cons)
`endif

`endif

@@ src/pcm_pkg.sv @@
package pcm_pkg;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic CFG_FALLBACK    = 1'b0;
    localparam logic CFG_UPPER_START = 1'b1;

    localparam logic [7:0] FALLBACK_RESET    = 8'd255;
    localparam logic [7:0] UPPER_START_RESET = 8'd128;

    localparam int SEARCH_MAX = 256;

    typedef enum logic [1:0] {
        KIND_EXACT    = 2'd0,
        KIND_NEAREST  = 2'd1,
        KIND_FALLBACK = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    typedef struct packed {
        logic wr;
        logic start;
        logic issue;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic last_addr;
        logic pipe_empty;
        logic out_free;
    } status_t;

endpackage

@@ src/pcm_ram.sv @@
module pcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/pcm_ctrl.sv @@
module pcm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             command,
    output logic             s_tready,
    input  pcm_pkg::status_t status,
    output pcm_pkg::cmd_t    cmd
);

    pcm_pkg::state_t state_reg;
    pcm_pkg::state_t state_next;
    logic            accept;

    assign s_tready = (state_reg == pcm_pkg::ST_IDLE);
    assign accept   = s_tvalid & s_tready;

    always_comb
    begin
        cmd.wr    = accept & (command == pcm_pkg::CMD_WRITE);
        cmd.start = accept & (command == pcm_pkg::CMD_LOOKUP);
        cmd.issue = (state_reg == pcm_pkg::ST_SCAN);
        cmd.load  = (state_reg == pcm_pkg::ST_DRAIN) & status.pipe_empty & status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pcm_pkg::ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = pcm_pkg::ST_SCAN;
                end
            end
            pcm_pkg::ST_SCAN:
            begin
                if (status.last_addr)
                begin
                    state_next = pcm_pkg::ST_DRAIN;
                end
            end
            pcm_pkg::ST_DRAIN:
            begin
                if (cmd.load)
                begin
                    state_next = pcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/pcm_datapath.sv @@
module pcm_datapath #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pcm_pkg::cmd_t    cmd,
    output pcm_pkg::status_t status,
    input  logic [7:0]       entry_index,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  logic             search_all,
    input  logic             allow_nearest,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [7:0]       found_index,
    output logic [1:0]       match_kind
);

    localparam int AW    = $clog2(PALETTE_ENTRIES);
    localparam int XW    = AW + 8;
    localparam int LIMIT = (PALETTE_ENTRIES < pcm_pkg::SEARCH_MAX) ?
                           PALETTE_ENTRIES : pcm_pkg::SEARCH_MAX;
    localparam int LW    = $clog2(LIMIT);

    logic [7:0]    fallback_reg;
    logic [7:0]    start_reg;
    logic [23:0]   color_reg;
    logic          search_all_reg;
    logic          allow_nearest_reg;

    logic [LW-1:0] scan_reg;
    logic          v1_reg;
    logic          v2_reg;
    logic [LW-1:0] idx1_reg;
    logic [LW-1:0] idx2_reg;
    logic [15:0]   sq_r_reg;
    logic [15:0]   sq_g_reg;
    logic [15:0]   sq_b_reg;
    logic          eq2_reg;
    logic          exact_ok2_reg;
    logic          upper2_reg;

    logic          exact_found_reg;
    logic [LW-1:0] exact_idx_reg;
    logic          have_reg;
    logic [LW-1:0] best_idx_reg;
    logic [17:0]   best_d_reg;

    logic          out_valid_reg;
    logic [7:0]    out_index_reg;
    logic [1:0]    out_kind_reg;

    logic [XW-1:0] idx_x;
    logic          wr_en;
    logic [AW-1:0] waddr;
    logic [23:0]   rd_data;
    logic [7:0]    dr;
    logic [7:0]    dg;
    logic [7:0]    db;
    logic [7:0]    idx1_w;
    logic          upper1;
    logic [17:0]   dist_sum;

    assign idx_x = XW'(entry_index);
    assign waddr = idx_x[AW-1:0];
    assign wr_en = cmd.wr & (idx_x < XW'(PALETTE_ENTRIES));

    pcm_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata ({red, green, blue}),
        .re    (cmd.issue),
        .raddr (AW'(scan_reg)),
        .rdata (rd_data)
    );

    assign status.last_addr  = cmd.issue & (scan_reg == LW'(LIMIT - 1));
    assign status.pipe_empty = ~v1_reg & ~v2_reg;
    assign status.out_free   = ~out_valid_reg | m_tready;

    always_comb
    begin
        dr       = (rd_data[23:16] > color_reg[23:16]) ? rd_data[23:16] - color_reg[23:16]
                                                       : color_reg[23:16] - rd_data[23:16];
        dg       = (rd_data[15:8] > color_reg[15:8]) ? rd_data[15:8] - color_reg[15:8]
                                                     : color_reg[15:8] - rd_data[15:8];
        db       = (rd_data[7:0] > color_reg[7:0]) ? rd_data[7:0] - color_reg[7:0]
                                                   : color_reg[7:0] - rd_data[7:0];
        idx1_w   = 8'(idx1_reg);
        upper1   = (idx1_w >= start_reg);
        dist_sum = 18'(sq_r_reg) + 18'(sq_g_reg) + 18'(sq_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_reg <= pcm_pkg::FALLBACK_RESET;
            start_reg    <= pcm_pkg::UPPER_START_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcm_pkg::CFG_FALLBACK:    fallback_reg <= cfg_data;
                pcm_pkg::CFG_UPPER_START: start_reg    <= cfg_data;
                default:                  fallback_reg <= fallback_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            color_reg         <= {red, green, blue};
            search_all_reg    <= search_all;
            allow_nearest_reg <= allow_nearest;
        end
        idx1_reg      <= scan_reg;
        idx2_reg      <= idx1_reg;
        sq_r_reg      <= 16'(dr) * 16'(dr);
        sq_g_reg      <= 16'(dg) * 16'(dg);
        sq_b_reg      <= 16'(db) * 16'(db);
        eq2_reg       <= (rd_data == color_reg);
        exact_ok2_reg <= search_all_reg | (idx1_reg == '0) | upper1;
        upper2_reg    <= upper1;
        if (v2_reg & eq2_reg & exact_ok2_reg & ~exact_found_reg)
        begin
            exact_idx_reg <= idx2_reg;
        end
        if (v2_reg & upper2_reg & (~have_reg | (dist_sum < best_d_reg)))
        begin
            best_idx_reg <= idx2_reg;
            best_d_reg   <= dist_sum;
        end
        if (cmd.load)
        begin
            if (exact_found_reg)
            begin
                out_index_reg <= 8'(exact_idx_reg);
                out_kind_reg  <= pcm_pkg::KIND_EXACT;
            end
            else if (allow_nearest_reg & have_reg)
            begin
                out_index_reg <= 8'(best_idx_reg);
                out_kind_reg  <= pcm_pkg::KIND_NEAREST;
            end
            else
            begin
                out_index_reg <= fallback_reg;
                out_kind_reg  <= pcm_pkg::KIND_FALLBACK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg        <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            exact_found_reg <= 1'b0;
            have_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.start)
            begin
                scan_reg        <= '0;
                exact_found_reg <= 1'b0;
                have_reg        <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (v2_reg & eq2_reg & exact_ok2_reg)
                begin
                    exact_found_reg <= 1'b1;
                end
                if (v2_reg & upper2_reg)
                begin
                    have_reg <= 1'b1;
                end
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign found_index = out_index_reg;
    assign match_kind  = out_kind_reg;

endmodule

@@ src/palette_color_matcher.sv @@
// Palette color matcher.
// Input stream (s_*): one word per command. A write command stores an RGB entry
// in the palette and gives no result. A lookup command scans the palette one
// entry per cycle through a single RAM read port, checking exact match and
// squared distance in the same pass, and gives one result word.
// Output stream (m_*): found_index and match_kind (exact, nearest, fallback).
// A lookup searches min(PALETTE_ENTRIES, 256) entries; the scan is the RAM
// read loop followed by a three-stage read/square/compare pipeline. A new
// command is taken in the cycle after the result is loaded, so a lookup
// finishes before the next command is taken; writes are taken at one per
// cycle while no lookup is running.
// Configuration port: cfg_we with cfg_index and cfg_data writes fallback_index
// (index 0) or upper_range_start (index 1); the user must do so only while no
// lookup is running; the block does not enforce it. Reset sets fallback_index
// to 255 and upper_range_start to 128 and empties the output register; palette
// entries hold no value until written. When m_tready is low a result holds
// in the output register; further write commands are still taken, and the
// next lookup waits at its end until the output register is free.
module palette_color_matcher #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // entry_index, red, green, blue
    input  logic [2:0]  s_tuser,  // command, search_all, allow_nearest
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // found_index
    output logic [1:0]  m_tuser,  // match_kind
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    `include "palette_color_matcher_assert.svh"

    pcm_pkg::cmd_t    cmd;
    pcm_pkg::status_t status;
    logic             lookup_accept;

    assign lookup_accept = s_tvalid & s_tready & (s_tuser[0] == pcm_pkg::CMD_LOOKUP);

    pcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .command  (s_tuser[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcm_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .entry_index   (s_tdata[7:0]),
        .red           (s_tdata[15:8]),
        .green         (s_tdata[23:16]),
        .blue          (s_tdata[31:24]),
        .search_all    (s_tuser[1]),
        .allow_nearest (s_tuser[2]),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .found_index   (m_tdata),
        .match_kind    (m_tuser)
    );

    `PCM_ASSERT_IMPL(a_ready_pipe_idle, clk, rst_n, s_tready, status.pipe_empty)
    `PCM_ASSERT_NEXT(a_lookup_busy, clk, rst_n, lookup_accept, !s_tready)
    `PCM_ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.load, m_tvalid)

endmodule

@@ tb/palette_color_matcher_tb.sv @@
`timescale 1ns / 1ps

module palette_color_matcher_tb;

    localparam int            ENTRY_COUNT   = 256;
    localparam int            SETTLE_CYCLES = ENTRY_COUNT + 12;
    localparam int            DRAIN_LIMIT   = 20000;
    localparam int            TIMEOUT_NS    = 4_000_000;
    localparam int            PHASE_WORDS   = 35;
    localparam logic [23:0]   KEY_MAGENTA   = 24'hFF00FF;
    localparam logic [23:0]   DUP_COLOR     = 24'h3C7A11;
    localparam logic [23:0]   TIE_LOW       = 24'h808080;
    localparam logic [23:0]   TIE_HIGH      = 24'h828282;
    localparam logic [23:0]   TIE_PROBE     = 24'h818181;

    typedef struct packed {
        logic [7:0]     index;
        pcm_pkg::kind_t kind;
    } lookup_answer_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // entry_index, red, green, blue
    logic [2:0]  s_tuser;   // command, search_all, allow_nearest
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // found_index
    logic [1:0]  m_tuser;   // match_kind
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    logic [23:0]    palette_copy [ENTRY_COUNT];
    logic [7:0]     fallback_copy;
    logic [7:0]     upper_start_copy;
    lookup_answer_t pending_answers [$];

    bit gaps_on;
    bit stalls_on;
    int stall_left;
    int mismatches;
    int failures;
    int writes_seen;
    int lookups_seen;
    int exact_seen;
    int nearest_seen;
    int fallback_seen;
    int settings_used;

    palette_color_matcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int color_distance(logic [23:0] a, logic [23:0] b);
        int dr;
        int dg;
        int db;
        dr = a[23:16];
        dr = dr - b[23:16];
        dg = a[15:8];
        dg = dg - b[15:8];
        db = a[7:0];
        db = db - b[7:0];
        return dr * dr + dg * dg + db * db;
    endfunction

    function automatic lookup_answer_t match_color(logic [23:0] color, logic whole,
                                                   logic near);
        lookup_answer_t answer;
        int             best_d;
        int             d;
        bit             have;
        answer.index = fallback_copy;
        answer.kind  = pcm_pkg::KIND_FALLBACK;
        have   = 1'b0;
        best_d = 0;
        if (whole)
        begin
            for (int i = 0; i < ENTRY_COUNT; i++)
                if (palette_copy[i] == color)
                begin
                    answer.index = 8'(i);
                    answer.kind  = pcm_pkg::KIND_EXACT;
                    return answer;
                end
        end
        else
        begin
            if (palette_copy[0] == color)
            begin
                answer.index = 8'd0;
                answer.kind  = pcm_pkg::KIND_EXACT;
                return answer;
            end
            for (int i = upper_start_copy; i < ENTRY_COUNT; i++)
                if (palette_copy[i] == color)
                begin
                    answer.index = 8'(i);
                    answer.kind  = pcm_pkg::KIND_EXACT;
                    return answer;
                end
        end
        if (near)
        begin
            for (int i = upper_start_copy; i < ENTRY_COUNT; i++)
            begin
                d = color_distance(color, palette_copy[i]);
                if (!have || d < best_d)
                begin
                    have         = 1'b1;
                    best_d       = d;
                    answer.index = 8'(i);
                    answer.kind  = pcm_pkg::KIND_NEAREST;
                end
            end
        end
        return answer;
    endfunction

    // track the palette and registers; check each result word
    always @(posedge clk)
    begin : monitor
        lookup_answer_t want;
        logic [23:0]    color;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == pcm_pkg::CFG_FALLBACK)
                    fallback_copy = cfg_data;
                else
                    upper_start_copy = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                color = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
                if (s_tuser[0] == pcm_pkg::CMD_WRITE)
                begin
                    palette_copy[s_tdata[7:0]] = color;
                    writes_seen++;
                end
                else
                begin
                    want = match_color(color, s_tuser[1], s_tuser[2]);
                    pending_answers.push_back(want);
                    lookups_seen++;
                    case (want.kind)
                        pcm_pkg::KIND_EXACT:   exact_seen++;
                        pcm_pkg::KIND_NEAREST: nearest_seen++;
                        default:               fallback_seen++;
                    endcase
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result word with none expected: index %0d kind %0d",
                                 m_tdata, m_tuser);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (m_tdata !== want.index || m_tuser !== want.kind)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected index %0d kind %0d, got index %0d kind %0d",
                                     want.index, want.kind, m_tdata, m_tuser);
                    end
                end
            end
        end
    end

    function automatic int pick_stall();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80)
            return $urandom_range(1, 3);
        else if (sel < 96)
            return $urandom_range(10, 60);
        return $urandom_range(60, 300);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 99) < 30)
        begin
            m_tready <= 1'b0;
            stall_left = pick_stall() - 1;
        end
        else
            m_tready <= 1'b1;
    end

    function automatic int pick_gap();
        int sel;
        if (!gaps_on)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        else if (sel < 92)
            return $urandom_range(1, 3);
        return $urandom_range(20, 120);
    endfunction

    function automatic logic [23:0] pick_entry_color();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return 24'h000000;
        else if (sel < 10)
            return 24'hFFFFFF;
        else if (sel < 14)
            return KEY_MAGENTA;
        else if (sel < 22)
            return DUP_COLOR;
        return 24'($urandom);
    endfunction

    function automatic logic [23:0] pick_probe_color();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return palette_copy[$urandom_range(0, ENTRY_COUNT - 1)];
        else if (sel < 65)
            return palette_copy[$urandom_range(0, ENTRY_COUNT - 1)] ^ 24'($urandom & 32'h070707);
        return 24'($urandom);
    endfunction

    // entered and left at a falling edge; valid stays high across back-to-back words
    task automatic send_word(input logic cmd, input logic [7:0] idx, input logic [23:0] color,
                             input logic whole, input logic near);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {color[7:0], color[15:8], color[23:16], idx};
        s_tuser  <= {near, whole, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_answers.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_registers(input logic [7:0] fallback, input logic [7:0] upper);
        wait_until_idle();
        cfg_we    <= 1'b1;
        cfg_index <= pcm_pkg::CFG_FALLBACK;
        cfg_data  <= fallback;
        @(negedge clk);
        cfg_index <= pcm_pkg::CFG_UPPER_START;
        cfg_data  <= upper;
        @(negedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    task automatic fill_palette();
        logic [23:0] color;
        for (int i = 0; i < ENTRY_COUNT; i++)
        begin
            if (i == 0)
                color = KEY_MAGENTA;
            else if (i == 1)
                color = 24'h000000;
            else if (i == ENTRY_COUNT - 1)
                color = 24'hFFFFFF;
            else if (i == 5 || i == 40 || i == 130 || i == 200)
                color = DUP_COLOR;
            else if (i == 150)
                color = TIE_LOW;
            else if (i == 151)
                color = TIE_HIGH;
            else
                color = pick_entry_color();
            send_word(pcm_pkg::CMD_WRITE, 8'(i), color, 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_directed_lookups();
        send_word(pcm_pkg::CMD_LOOKUP, 8'h00, DUP_COLOR, 1'b1, 1'b0);
        send_word(pcm_pkg::CMD_LOOKUP, 8'hFF, DUP_COLOR, 1'b0, 1'b0);
        send_word(pcm_pkg::CMD_LOOKUP, 8'h00, KEY_MAGENTA, 1'b0, 1'b1);
        send_word(pcm_pkg::CMD_LOOKUP, 8'h00, 24'h000000, 1'b1, 1'b0);
        send_word(pcm_pkg::CMD_LOOKUP, 8'h00, 24'h000000, 1'b0, 1'b0);
        send_word(pcm_pkg::CMD_LOOKUP, 8'h00, 24'h000000, 1'b0, 1'b1);
        send_word(pcm_pkg::CMD_LOOKUP, 8'h00, 24'hFFFFFF, 1'b1, 1'b1);
        send_word(pcm_pkg::CMD_LOOKUP, 8'h00, 24'hFFFFFF, 1'b0, 1'b0);
        // equal distance to two entries: lower index wins
        send_word(pcm_pkg::CMD_LOOKUP, 8'h00, TIE_PROBE, 1'b1, 1'b1);
        send_word(pcm_pkg::CMD_LOOKUP, 8'h00, TIE_PROBE, 1'b0, 1'b1);
        send_word(pcm_pkg::CMD_LOOKUP, 8'h00, TIE_PROBE, 1'b0, 1'b0);
        send_word(pcm_pkg::CMD_LOOKUP, 8'h00, TIE_PROBE, 1'b1, 1'b0);
        send_word(pcm_pkg::CMD_WRITE, 8'hFF, TIE_PROBE, 1'b0, 1'b0);
        send_word(pcm_pkg::CMD_LOOKUP, 8'h00, TIE_PROBE, 1'b0, 1'b0);
        send_word(pcm_pkg::CMD_WRITE, 8'h00, 24'h123456, 1'b1, 1'b1);
        send_word(pcm_pkg::CMD_LOOKUP, 8'h00, 24'h123456, 1'b1, 1'b0);
        send_word(pcm_pkg::CMD_WRITE, 8'h00, KEY_MAGENTA, 1'b0, 1'b0);
        send_word(pcm_pkg::CMD_LOOKUP, 8'hFF, 24'hFFFFFF, 1'b0, 1'b1);
    endtask

    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 45)
                send_word(pcm_pkg::CMD_WRITE, 8'($urandom), pick_entry_color(),
                          1'($urandom), 1'($urandom));
            else
                send_word(pcm_pkg::CMD_LOOKUP, 8'($urandom), pick_probe_color(),
                          1'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_register_sweep();
        logic [7:0] fallback_set [5];
        logic [7:0] upper_set [5];
        fallback_set = '{8'd0, 8'd255, 8'd1, 8'd73, 8'($urandom)};
        upper_set    = '{8'd0, 8'd255, 8'd254, 8'd1, 8'($urandom)};
        for (int p = 0; p < 5; p++)
        begin
            write_registers(fallback_set[p], upper_set[p]);
            gaps_on   = (p != 2);
            stalls_on = (p != 2);
            test_random_traffic(PHASE_WORDS);
        end
    endtask

    initial
    begin
        int waited;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_index = pcm_pkg::CFG_FALLBACK;
        cfg_data  = '0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        fallback_copy    = pcm_pkg::FALLBACK_RESET;
        upper_start_copy = pcm_pkg::UPPER_START_RESET;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        fill_palette();
        test_directed_lookups();
        test_register_sweep();

        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_answers.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_answers.size() != 0)
        begin
            failures++;
            $display("%0d lookup results never arrived", pending_answers.size());
        end

        $display("Sent %0d palette writes and %0d lookups under %0d register settings",
                 writes_seen, lookups_seen, settings_used + 1);
        $display("Lookup outcomes: %0d exact, %0d nearest, %0d fallback",
                 exact_seen, nearest_seen, fallback_seen);
        if (mismatches == 0 && failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d lookup results outstanding", pending_answers.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
